/* src/prbd_pkg.sv */
// Shared types and codes for the PackBits row decoder; depends on nothing.
// Used by prbd_csr, prbd_decode, packbits_row_decoder_core, prbd_run_checker and the test.
package prbd_pkg;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_REPEAT  = 2'd1,
      PH_LITERAL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_OVERFLOW    = 2'd1,
      ST_SRC_OVERRUN = 2'd2
   } status_type;

   // register index of row_length in the CSR map
   localparam logic CSR_ROW_LENGTH = 1'b0;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CFG_FIELD_BITS = 16;

   localparam logic [7:0] HDR_NOP = 8'd128;
   localparam logic [8:0] RUN_BASE = 9'd257;

   typedef struct packed {
      logic [7:0] out_value;
      logic [7:0] run_count;
      logic       row_done;
      status_type row_status;
   } result_type;

endpackage

/* src/prbd_csr.sv */
// APB-style configuration register file: holds row_length.
// Depends on prbd_pkg for the register index and port widths.
module prbd_csr #(
   parameter int ROW_LEN_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [prbd_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [prbd_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [prbd_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output logic [ROW_LEN_BITS-1:0]                row_length
);

   localparam int FIELD_BITS = (ROW_LEN_BITS < prbd_pkg::CFG_FIELD_BITS) ?
                               ROW_LEN_BITS : prbd_pkg::CFG_FIELD_BITS;

   logic [ROW_LEN_BITS-1:0] row_length_ff;
   logic [ROW_LEN_BITS-1:0] row_length_in;
   logic                    sel_row_length;
   logic                    wr_en;

   assign sel_row_length = (csr_paddr[2] == prbd_pkg::CSR_ROW_LENGTH);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      row_length_in = row_length_ff;
      if (wr_en && sel_row_length) begin
         // keep only the low field bits, clipped to the position width
         row_length_in = ROW_LEN_BITS'(csr_pwdata[FIELD_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LEN_BITS'(1);
      end else begin
         row_length_ff <= row_length_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_row_length ?
                       prbd_pkg::CSR_DATA_BITS'(row_length_ff) : '0;
   assign row_length = row_length_ff;

endmodule

/* src/prbd_decode.sv */
// Row decode state (phase, pending count, output position, error) and the
// one-byte step logic. Depends on prbd_pkg for phase/status codes and result type.
module prbd_decode #(
   parameter int ROW_LEN_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               code_byte,
   input  logic                     row_last,
   input  logic [ROW_LEN_BITS-1:0]  row_length,
   output logic                     emit,
   output prbd_pkg::result_type     result
);

   localparam int CW = ROW_LEN_BITS + 1;

   prbd_pkg::phase_type     phase_ff, phase_in;
   logic [7:0]              pending_ff, pending_in;
   logic [ROW_LEN_BITS-1:0] pos_ff, pos_in;
   prbd_pkg::status_type    err_ff, err_in;

   logic                    row_full;
   logic [ROW_LEN_BITS-1:0] room;
   logic [7:0]              count;
   logic [7:0]              value;
   logic [7:0]              pending_dec;
   logic                    produce;

   assign row_full = (pos_ff >= row_length);
   assign room = row_full ? '0 : (row_length - pos_ff);
   assign pending_dec = (pending_ff != 8'd0) ? (pending_ff - 8'd1) : 8'd0;

   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      pos_in     = pos_ff;
      err_in     = err_ff;
      count      = 8'd0;
      value      = 8'd0;
      produce    = 1'b0;

      if (err_ff == prbd_pkg::ST_OK) begin
         unique case (phase_ff)
            prbd_pkg::PH_HEADER: begin
               if (!row_last) begin
                  if (row_full) begin
                     err_in = prbd_pkg::ST_OVERFLOW;
                  end else if (code_byte > prbd_pkg::HDR_NOP) begin
                     pending_in = 8'(prbd_pkg::RUN_BASE - {1'b0, code_byte});
                     phase_in   = prbd_pkg::PH_REPEAT;
                  end else if (code_byte < prbd_pkg::HDR_NOP) begin
                     pending_in = code_byte + 8'd1;
                     phase_in   = prbd_pkg::PH_LITERAL;
                  end
               end
            end
            prbd_pkg::PH_REPEAT: begin
               count = pending_ff;
               // clip the run to the room left in the row
               if (CW'(pending_ff) > CW'(room)) begin
                  count  = room[7:0];
                  err_in = prbd_pkg::ST_OVERFLOW;
               end
               value      = code_byte;
               pos_in     = pos_ff + ROW_LEN_BITS'(count);
               pending_in = 8'd0;
               phase_in   = prbd_pkg::PH_HEADER;
               produce    = 1'b1;
            end
            default: begin
               if (row_full) begin
                  err_in = prbd_pkg::ST_OVERFLOW;
               end else begin
                  value      = code_byte;
                  count      = 8'd1;
                  pos_in     = pos_ff + ROW_LEN_BITS'(1);
                  produce    = 1'b1;
                  pending_in = pending_dec;
                  if (pending_dec == 8'd0) begin
                     phase_in = prbd_pkg::PH_HEADER;
                  end else if (row_last) begin
                     err_in = prbd_pkg::ST_SRC_OVERRUN;
                  end
               end
            end
         endcase
      end

      emit = produce || row_last;
      result.out_value  = (count == 8'd0) ? 8'd0 : value;
      result.run_count  = count;
      result.row_done   = row_last;
      result.row_status = row_last ? err_in : prbd_pkg::ST_OK;

      // the final byte returns the row state to its start
      if (row_last) begin
         phase_in   = prbd_pkg::PH_HEADER;
         pending_in = 8'd0;
         pos_in     = '0;
         err_in     = prbd_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= prbd_pkg::PH_HEADER;
         pending_ff <= 8'd0;
         pos_ff     <= '0;
         err_ff     <= prbd_pkg::ST_OK;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         pos_ff     <= pos_in;
         err_ff     <= err_in;
      end
   end

endmodule

/* src/packbits_row_decoder_core.sv */
// PackBits row decoder top level: input register, decode step, result register.
// Depends on prbd_pkg, prbd_csr and prbd_decode.
//
// Usage: one compressed byte of a row enters per request on the req_ channel
// (req_code_byte, req_row_last marks the row's final byte). Each run or literal
// byte comes out on the rsp_ channel as a value and repeat count; the row's
// final byte always gives a result with rsp_row_done set and the row status
// (ok, output overflow, source ended inside a literal). Header bytes and bytes
// dropped after an error give no result. row_length is set through the csr_ port
// at byte address 0 by the user only while idle; the block does not enforce this.
// Path: an accepted request is held in the input register, passes the decode step
// and its result is captured in the result register.
// Throughput: one request per cycle while no pending result is stalled; the
// decode step between the input register and the result register is combinational.
// Stall: while rsp_stall holds a pending result, the input register holds its
// request and req_stall rises; no request is lost or repeated.
// Reset: synchronous; row state clears, row_length returns to 1, both
// registers empty.
module packbits_row_decoder_core #(
   parameter int ROW_LEN_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_code_byte,
   input  logic                                req_row_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_value,
   output logic [7:0]                          rsp_run_count,
   output logic                                rsp_row_done,
   output logic [1:0]                          rsp_row_status,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prbd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [prbd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [prbd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [ROW_LEN_BITS-1:0] row_length;

   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 advance;
   logic                 emit;
   prbd_pkg::result_type result;
   logic                 rsp_vld_ff, rsp_vld_in;
   prbd_pkg::result_type rsp_ff;

   prbd_csr #(
      .ROW_LEN_BITS(ROW_LEN_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .row_length  (row_length)
   );

   prbd_decode #(
      .ROW_LEN_BITS(ROW_LEN_BITS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .code_byte  (in_byte_ff),
      .row_last   (in_last_ff),
      .row_length (row_length),
      .emit       (emit),
      .result     (result)
   );

   // advance the held request when the result register is free or draining
   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && rsp_vld_ff && rsp_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (!req_stall) begin
         in_vld_in = req_valid;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = emit;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_code_byte;
         in_last_ff <= req_row_last;
      end
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_out_value  = rsp_ff.out_value;
   assign rsp_run_count  = rsp_ff.run_count;
   assign rsp_row_done   = rsp_ff.row_done;
   assign rsp_row_status = rsp_ff.row_status;

endmodule

/* dv/prbd_run_checker.sv */
// Run checker for packbits_row_decoder_core: follows row_length through CSR
// writes, predicts each decoded run and row status, and compares results in order.
// Depends on prbd_pkg.
`timescale 1ns / 1ps

module prbd_run_checker #(
   parameter int ROW_LEN_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [7:0]                          req_code_byte,
   input  logic                                req_row_last,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [7:0]                          rsp_out_value,
   input  logic [7:0]                          rsp_run_count,
   input  logic                                rsp_row_done,
   input  logic [1:0]                          rsp_row_status,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prbd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [prbd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  runs_pending,
   output int                                  runs_checked
);

   localparam logic [prbd_pkg::CSR_ADDR_BITS-1:0] ROW_LENGTH_ADDR =
      prbd_pkg::CSR_ADDR_BITS'(4 * prbd_pkg::CSR_ROW_LENGTH);

   logic [ROW_LEN_BITS-1:0] row_len;
   logic [ROW_LEN_BITS-1:0] out_pos;
   prbd_pkg::phase_type     dec_phase;
   prbd_pkg::status_type    row_err;
   int unsigned             bytes_owed;
   prbd_pkg::result_type    expected_runs[$];

   initial begin
      fail_count   = 0;
      runs_pending = 0;
      runs_checked = 0;
   end

   task automatic clear_row();
      dec_phase  = prbd_pkg::PH_HEADER;
      bytes_owed = 0;
      out_pos    = '0;
      row_err    = prbd_pkg::ST_OK;
   endtask

   task automatic decode_byte(input logic [7:0] code, input logic last);
      prbd_pkg::result_type run;
      logic [7:0]           value;
      longint               count;
      longint               room;
      bit                   emit;
      value = '0;
      count = 0;
      emit  = 1'b0;
      if (row_err == prbd_pkg::ST_OK) begin
         case (dec_phase)
            prbd_pkg::PH_HEADER: begin
               // a header on the row's final byte starts nothing
               if (!last) begin
                  if (out_pos >= row_len) begin
                     row_err = prbd_pkg::ST_OVERFLOW;
                  end else if (code > prbd_pkg::HDR_NOP) begin
                     bytes_owed = int'(prbd_pkg::RUN_BASE) - int'(code);
                     dec_phase  = prbd_pkg::PH_REPEAT;
                  end else if (code < prbd_pkg::HDR_NOP) begin
                     bytes_owed = int'(code) + 1;
                     dec_phase  = prbd_pkg::PH_LITERAL;
                  end
               end
            end
            prbd_pkg::PH_REPEAT: begin
               room  = (out_pos < row_len) ?
                       longint'(row_len) - longint'(out_pos) : 0;
               count = bytes_owed;
               // clip the run to what is left of the row
               if (count > room) begin
                  count   = room;
                  row_err = prbd_pkg::ST_OVERFLOW;
               end
               value      = code;
               out_pos    = out_pos + ROW_LEN_BITS'(count);
               bytes_owed = 0;
               dec_phase  = prbd_pkg::PH_HEADER;
               emit       = 1'b1;
            end
            default: begin
               if (out_pos >= row_len) begin
                  row_err = prbd_pkg::ST_OVERFLOW;
               end else begin
                  value   = code;
                  count   = 1;
                  out_pos = out_pos + 1'b1;
                  emit    = 1'b1;
                  if (bytes_owed > 0) bytes_owed--;
                  if (bytes_owed == 0) begin
                     dec_phase = prbd_pkg::PH_HEADER;
                  end else if (last) begin
                     row_err = prbd_pkg::ST_SRC_OVERRUN;
                  end
               end
            end
         endcase
      end
      if (emit || last) begin
         run.out_value  = (count == 0) ? 8'd0 : value;
         run.run_count  = 8'(count);
         run.row_done   = last;
         run.row_status = last ? row_err : prbd_pkg::ST_OK;
         expected_runs.insert(expected_runs.size(), run);
      end
      if (last) clear_row();
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      prbd_pkg::result_type want;
      runs_checked++;
      if (expected_runs.size() == 0) begin
         fail_count++;
         $display("%0t: result expected none, actual value %0d count %0d done %0b status %0d",
                  $time, rsp_out_value, rsp_run_count, rsp_row_done, rsp_row_status);
         return;
      end
      want = expected_runs.pop_front();
      compare_field("out_value", want.out_value, rsp_out_value);
      compare_field("run_count", want.run_count, rsp_run_count);
      compare_field("row_done", 8'(want.row_done), 8'(rsp_row_done));
      compare_field("row_status", 8'(want.row_status), 8'(rsp_row_status));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_len = ROW_LEN_BITS'(1);
         clear_row();
         expected_runs.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ROW_LENGTH_ADDR) begin
            row_len = ROW_LEN_BITS'(csr_pwdata[prbd_pkg::CFG_FIELD_BITS-1:0]);
         end
         if (req_valid && !req_stall) decode_byte(req_code_byte, req_row_last);
         if (rsp_valid && !rsp_stall) check_result();
      end
      runs_pending = expected_runs.size();
   end

endmodule

/* dv/packbits_row_decoder_core_test.sv */
// Top of the packbits_row_decoder_core testbench: clock, reset, row stimulus,
// CSR writes and the verdict. Depends on prbd_pkg, prbd_run_checker and the block.
`timescale 1ns / 1ps

module packbits_row_decoder_core_test;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int REQUEST_GOAL  = 1100;
   localparam int PHASE_SPAN    = 120;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [prbd_pkg::CSR_ADDR_BITS-1:0] ROW_LENGTH_ADDR =
      prbd_pkg::CSR_ADDR_BITS'(4 * prbd_pkg::CSR_ROW_LENGTH);

   logic                               clock         = 1'b0;
   logic                               reset         = 1'b1;
   logic                               req_valid     = 1'b0;
   logic                               req_stall;
   logic [7:0]                         req_code_byte = '0;
   logic                               req_row_last  = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall     = 1'b0;
   logic [7:0]                         rsp_out_value;
   logic [7:0]                         rsp_run_count;
   logic                               rsp_row_done;
   logic [1:0]                         rsp_row_status;
   logic                               csr_psel      = 1'b0;
   logic                               csr_penable   = 1'b0;
   logic                               csr_pwrite    = 1'b0;
   logic [prbd_pkg::CSR_ADDR_BITS-1:0] csr_paddr     = '0;
   logic [prbd_pkg::CSR_DATA_BITS-1:0] csr_pwdata    = '0;
   logic [prbd_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   int fail_count;
   int runs_pending;
   int runs_checked;

   int          idle_max      = 2;
   int          requests_sent = 0;
   int          rows_sent     = 0;
   int          settings_used = 0;
   int          cycle_count   = 0;
   int          rsp_taken     = 0;
   int          rsp_seen      = 0;
   int          rsp_wait      = 0;
   logic [7:0]  row_bytes[$];
   int unsigned row_settings[7] = '{1, 5, 65535, 0, 12, 3, 30};

   packbits_row_decoder_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_byte  (req_code_byte),
      .req_row_last   (req_row_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_run_count  (rsp_run_count),
      .rsp_row_done   (rsp_row_done),
      .rsp_row_status (rsp_row_status),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   prbd_run_checker run_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_byte  (req_code_byte),
      .req_row_last   (req_row_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_run_count  (rsp_run_count),
      .rsp_row_done   (rsp_row_done),
      .rsp_row_status (rsp_row_status),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .runs_pending   (runs_pending),
      .runs_checked   (runs_checked)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int draw_gap();
      return $urandom_range(0, idle_max);
   endfunction

   // hold each result for a freshly drawn number of cycles after the last one is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) rsp_taken++;
   end

   always @(negedge clock) begin
      if (rsp_taken != rsp_seen) begin
         rsp_seen = rsp_taken;
         rsp_wait = draw_gap();
      end
      rsp_stall = (rsp_wait > 0);
      if (rsp_wait > 0) rsp_wait--;
   end

   task automatic send_code(input logic [7:0] code, input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_code_byte = code;
      req_row_last  = last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic send_row();
      foreach (row_bytes[i]) send_code(row_bytes[i], i == row_bytes.size() - 1);
      rows_sent++;
   endtask

   task automatic add_byte(input logic [7:0] code);
      row_bytes.insert(row_bytes.size(), code);
   endtask

   task automatic write_row_length(input logic [15:0] len);
      req_valid = 1'b0;
      // drain, then let header bytes still in flight clear the pipeline
      while (runs_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ROW_LENGTH_ADDR;
      csr_pwdata  = {16'($urandom), len};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      settings_used++;
   endtask

   // append headers and payload that decode to exactly total bytes
   task automatic append_runs(input int total);
      int left;
      int n;
      left = total;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) add_byte(prbd_pkg::HDR_NOP);
         n = $urandom_range(1, (left < 128) ? left : 128);
         if (n > 1 && $urandom_range(0, 1) == 1) begin
            add_byte(8'(int'(prbd_pkg::RUN_BASE) - n));
            add_byte(8'($urandom));
         end else begin
            add_byte(8'(n - 1));
            repeat (n) add_byte(8'($urandom));
         end
         left -= n;
      end
   endtask

   task automatic build_row(input int unsigned row_len);
      int fill;
      int kind;
      int cut;
      row_bytes.delete();
      fill = (row_len > 200) ? $urandom_range(1, 200) : row_len;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         append_runs(fill);
      end else if (kind == 7) begin
         append_runs(fill + $urandom_range(1, 40));
      end else if (kind == 8) begin
         // drop the tail so the row may end mid-run or mid-literal
         append_runs(fill);
         cut = $urandom_range(1, 3);
         while (cut > 0 && row_bytes.size() > 1) begin
            void'(row_bytes.pop_back());
            cut--;
         end
      end else begin
         repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
      end
      if (row_bytes.size() == 0) add_byte(8'($urandom));
   endtask

   initial begin
      int unsigned setting;
      int          phase_start;
      int          p;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      write_row_length(16'd6);
      // literal, skip header, run, run clipped by the row end, dropped byte
      row_bytes = '{8'h02, 8'h00, 8'hFF, 8'hA5, 8'h80, 8'hFF, 8'h5A, 8'h81, 8'h33,
                    8'h11, 8'h7F};
      send_row();
      // longest literal cut short by the row end
      row_bytes = '{8'h7F, 8'h01, 8'h02};
      send_row();
      // header alone as the final byte
      row_bytes = '{8'h05};
      send_row();
      // header arriving with the row already full
      row_bytes = '{8'hFB, 8'h44, 8'h01, 8'h00};
      send_row();
      // literal byte arriving with the row already full
      row_bytes = '{8'hFC, 8'h44, 8'h01, 8'h10, 8'h20, 8'h30};
      send_row();

      p = 0;
      while (requests_sent < REQUEST_GOAL) begin
         setting = (p < 7) ? row_settings[p] : $urandom_range(1, 48);
         p++;
         write_row_length(16'(setting));
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_SPAN &&
                requests_sent < REQUEST_GOAL) begin
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            build_row(setting);
            send_row();
         end
      end
      req_valid = 1'b0;

      while (runs_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Decoded %0d code bytes in %0d rows across %0d row_length values,",
               requests_sent, rows_sent, settings_used);
      $display("0 and 65535 among them; checked %0d results, %0d field mismatches",
               runs_checked, fail_count);
      if (fail_count == 0 && runs_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
src/prbd_pkg.sv
src/prbd_csr.sv
src/prbd_decode.sv
src/packbits_row_decoder_core.sv
dv/prbd_run_checker.sv
dv/packbits_row_decoder_core_test.sv
